[rtl/core/hsd_pkg.sv]
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared types, function codes and sizing constants for the dispatch core.
// ----------------------------------------------------------------------------
package hsd_pkg;

    localparam int NUM_STATES_DEF      = 16;
    localparam int NUM_TRANSITIONS_DEF = 32;

    localparam logic [2:0] FUNC_LOAD_STATE = 3'd0;
    localparam logic [2:0] FUNC_LOAD_TRANS = 3'd1;
    localparam logic [2:0] FUNC_DISPATCH   = 3'd2;
    localparam logic [2:0] FUNC_SET_ACTIVE = 3'd3;
    localparam logic [2:0] FUNC_READ_HIST  = 3'd4;
    localparam logic [2:0] FUNC_WRITE_HIST = 3'd5;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  slot;
        logic [3:0]  state_id;
        logic [3:0]  link_state;
        logic        has_link;
        logic        keeps_history;
        logic        entry_valid;
        logic        is_external;
        logic [15:0] trans_id;
        logic [15:0] event_code;
        logic [15:0] rank;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [15:0] chosen_id;
        logic [3:0]  chosen_target;
        logic        chosen_external;
        logic [3:0]  previous_state;
        logic [3:0]  now_active;
        logic [3:0]  history_child;
        logic        history_valid;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic capture;  // latch item, run non-dispatch functions, start walk
        logic step;     // evaluate one level of the parent walk
        logic finish;   // commit dispatch outcome
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_dispatch;
        logic walk_done;
    } t_sts;

endpackage

[rtl/core/hsd_ctrl.sv]
// ----------------------------------------------------------------------------
// hsd_ctrl
// Sequencer: accept a transaction, walk levels, hand result to output stage.
// ----------------------------------------------------------------------------
module hsd_ctrl
    import hsd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE) && w_out_free;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !i_out_ready;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.is_dispatch) begin
                        n_state = ST_WALK;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                o_cmd.step = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[rtl/core/hsd_datapath.sv]
// ----------------------------------------------------------------------------
// hsd_datapath
// State, transition and history tables, level matcher and result register.
// ----------------------------------------------------------------------------
module hsd_datapath
    import hsd_pkg::*;
#(
    parameter int NUM_STATES      = NUM_STATES_DEF,
    parameter int NUM_TRANSITIONS = NUM_TRANSITIONS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output t_out_item o_result
);

    localparam int SW = 4;
    localparam int LW = $clog2(NUM_STATES + 1);
    localparam int XW = $clog2(NUM_STATES);
    localparam int TW = $clog2(NUM_TRANSITIONS) > 0 ? $clog2(NUM_TRANSITIONS) : 1;
    localparam int NP = 1 << TW;

    typedef struct packed {
        logic        hit;
        logic [15:0] rank;
        logic [15:0] id;
        logic [3:0]  tgt;
        logic        ext;
    } t_cand;

    // state table
    logic [NUM_STATES-1:0] r_st_haspar, r_st_hist;
    logic [SW-1:0]         r_st_par [NUM_STATES];
    // transition table
    logic [NUM_TRANSITIONS-1:0] r_tr_valid;
    logic                       r_tr_ext [NUM_TRANSITIONS];
    logic [SW-1:0]              r_tr_src [NUM_TRANSITIONS];
    logic [SW-1:0]              r_tr_tgt [NUM_TRANSITIONS];
    logic [15:0]                r_tr_id  [NUM_TRANSITIONS];
    logic [15:0]                r_tr_ev  [NUM_TRANSITIONS];
    logic [15:0]                r_tr_rank[NUM_TRANSITIONS];
    // history
    logic [NUM_STATES-1:0] r_h_valid;
    logic [SW-1:0]         r_h_child [NUM_STATES];

    logic [SW-1:0] r_cur;
    logic [SW-1:0] r_walk;
    logic [LW-1:0] r_level;
    logic [15:0]   r_event;
    logic          r_found;
    logic [15:0]   r_b_id;
    logic [3:0]    r_b_tgt;
    logic          r_b_ext;
    t_out_item     r_res;

    function automatic logic in_range(input logic [SW-1:0] s);
        return 32'(s) < NUM_STATES;
    endfunction

    function automatic t_cand pick_best(input t_cand a, input t_cand b);
        if (b.hit && (!a.hit || b.rank < a.rank ||
                (b.rank == a.rank && b.id < a.id))) begin
            return b;
        end
        return a;
    endfunction

    // one level: best match among all slots for source r_walk, reduced as a tree
    t_cand       w_node [2*NP];
    logic        w_hit;
    logic [15:0] w_id;
    logic [3:0]  w_tgt;
    logic        w_ext;
    always_comb begin
        w_node[0] = '0;
        for (int i = 0; i < NP; i++) begin
            w_node[NP+i] = '0;
            if (i < NUM_TRANSITIONS) begin
                w_node[NP+i].hit  = r_tr_valid[i] && r_tr_src[i] == r_walk &&
                                    r_tr_ev[i] == r_event;
                w_node[NP+i].rank = r_tr_rank[i];
                w_node[NP+i].id   = r_tr_id[i];
                w_node[NP+i].tgt  = r_tr_tgt[i];
                w_node[NP+i].ext  = r_tr_ext[i];
            end
        end
        for (int n = NP - 1; n >= 1; n--) begin
            w_node[n] = pick_best(w_node[2*n], w_node[2*n+1]);
        end
    end

    assign w_hit = w_node[1].hit;
    assign w_id  = w_node[1].id;
    assign w_tgt = w_node[1].tgt;
    assign w_ext = w_node[1].ext;

    logic          w_par_ok;
    logic [SW-1:0] w_par;
    assign w_par_ok = in_range(r_walk) && r_st_haspar[r_walk[XW-1:0]];
    assign w_par    = r_st_par[r_walk[XW-1:0]];

    assign o_sts.is_dispatch = (i_item.func == FUNC_DISPATCH);
    assign o_sts.walk_done   = w_hit || !w_par_ok || (32'(r_level) + 1 >= NUM_STATES);
    assign o_result          = r_res;

    // history record target for external dispatch
    logic          w_act_par;
    logic [SW-1:0] w_ap;
    assign w_act_par = in_range(r_cur) && r_st_haspar[r_cur[XW-1:0]];
    assign w_ap      = r_st_par[r_cur[XW-1:0]];

    // result on capture and on dispatch commit
    t_out_item w_cap;
    t_out_item w_fin;
    always_comb begin
        w_cap                = '0;
        w_cap.previous_state = r_cur;
        w_cap.now_active     = r_cur;
        if (i_item.func == FUNC_SET_ACTIVE) begin
            w_cap.now_active = i_item.state_id;
        end
        if (i_item.func == FUNC_READ_HIST && in_range(i_item.state_id)
                && r_h_valid[i_item.state_id[XW-1:0]]) begin
            w_cap.history_valid = 1'b1;
            w_cap.history_child = r_h_child[i_item.state_id[XW-1:0]];
        end
    end

    always_comb begin
        w_fin = r_res;
        if (!r_found) begin
            w_fin.status = 1'b1;
        end else begin
            w_fin.chosen_id       = r_b_id;
            w_fin.chosen_target   = r_b_tgt;
            w_fin.chosen_external = r_b_ext;
            if (r_b_ext) begin
                w_fin.now_active = r_b_tgt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_haspar <= '0;
            r_st_hist   <= '0;
            r_tr_valid  <= '0;
            r_h_valid   <= '0;
            r_cur       <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_res   <= w_cap;
                r_event <= i_item.event_code;
                r_walk  <= r_cur;
                r_level <= '0;
                r_found <= 1'b0;
                unique case (i_item.func)
                    FUNC_LOAD_STATE: begin
                        if (in_range(i_item.state_id)) begin
                            r_st_haspar[i_item.state_id[XW-1:0]] <=
                                i_item.entry_valid && i_item.has_link;
                            r_st_hist  [i_item.state_id[XW-1:0]] <=
                                i_item.entry_valid && i_item.keeps_history;
                            r_st_par   [i_item.state_id[XW-1:0]] <=
                                i_item.entry_valid ? i_item.link_state : '0;
                        end
                    end
                    FUNC_LOAD_TRANS: begin
                        if (32'(i_item.slot) < NUM_TRANSITIONS) begin
                            r_tr_valid[i_item.slot[TW-1:0]] <= i_item.entry_valid;
                            r_tr_ext  [i_item.slot[TW-1:0]] <= i_item.is_external;
                            r_tr_src  [i_item.slot[TW-1:0]] <= i_item.state_id;
                            r_tr_tgt  [i_item.slot[TW-1:0]] <= i_item.link_state;
                            r_tr_id   [i_item.slot[TW-1:0]] <= i_item.trans_id;
                            r_tr_ev   [i_item.slot[TW-1:0]] <= i_item.event_code;
                            r_tr_rank [i_item.slot[TW-1:0]] <= i_item.rank;
                        end
                    end
                    FUNC_SET_ACTIVE: begin
                        r_cur     <= i_item.state_id;
                        r_h_valid <= '0;
                    end
                    FUNC_WRITE_HIST: begin
                        if (in_range(i_item.state_id)) begin
                            r_h_valid[i_item.state_id[XW-1:0]] <= 1'b1;
                            r_h_child[i_item.state_id[XW-1:0]] <= i_item.link_state;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.step) begin
                r_level <= r_level + 1'b1;
                if (w_hit) begin
                    r_found <= 1'b1;
                    r_b_id  <= w_id;
                    r_b_tgt <= w_tgt;
                    r_b_ext <= w_ext;
                end else if (w_par_ok) begin
                    r_walk <= w_par;
                end
            end
            if (i_cmd.finish) begin
                r_res <= w_fin;
                if (r_found && r_b_ext) begin
                    if (w_act_par && in_range(w_ap) && r_st_hist[w_ap[XW-1:0]]) begin
                        r_h_valid[w_ap[XW-1:0]] <= 1'b1;
                        r_h_child[w_ap[XW-1:0]] <= r_cur;
                    end
                    r_cur <= r_b_tgt;
                end
            end
        end
    end

endmodule

[rtl/core/hierarchical_statechart_dispatch_core.sv]
// ----------------------------------------------------------------------------
// hierarchical_statechart_dispatch_core
// Table-driven hierarchical state machine: loads, dispatch, history access.
// ----------------------------------------------------------------------------
//   channel   direction   handshake                 payload
//   in        input       i_in_valid / o_in_ready   i_in_item  (t_in_item)
//   out       output      o_out_valid / i_out_ready o_out_item (t_out_item)
//
// Non-dispatch transactions execute on accept; the result shows the next cycle.
// Dispatch walks L = parent levels visited (1..NUM_STATES), then commits,
// one level per cycle through the all-slot matcher.
// Synchronous active-low reset clears the valid and flag bits of all tables and the active state.
// A result held by a stalled output blocks the next accept and the next
// dispatch commit.
// ----------------------------------------------------------------------------
module hierarchical_statechart_dispatch_core
    import hsd_pkg::*;
#(
    parameter int NUM_STATES      = NUM_STATES_DEF,
    parameter int NUM_TRANSITIONS = NUM_TRANSITIONS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_cmd w_cmd;
    t_sts w_sts;

    hsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    hsd_datapath #(
        .NUM_STATES      (NUM_STATES),
        .NUM_TRANSITIONS (NUM_TRANSITIONS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_item),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (o_out_item)
    );

`ifndef SYNTH
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_cmd.capture, w_cmd.step, w_cmd.finish}) <= 1)
        else $error("overlapping commands");
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |=> o_out_valid)
        else $error("finish without result");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.step || w_cmd.finish) |-> !o_in_ready)
        else $error("accept while busy");
`endif

endmodule
